// ===== sv/psdp_pkg.sv =====
// Shared types and constants for the PSI section descriptor parser.
// Holds the result record, the push bundle, status codes and byte positions.
// No dependencies.
package psdp_pkg;

	localparam int BYTE_CNT_W = 13;
	localparam int LOOP_W     = 14;
	localparam int CFG_IDX_W  = 4;
	localparam int RQ_DEPTH   = 4;
	localparam int RQ_PTR_W   = 2;
	localparam int RQ_CNT_W   = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BYTES = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 4'd1;

	localparam logic [BYTE_CNT_W-1:0] MIN_BYTES_RST = 13'd12;
	localparam logic [BYTE_CNT_W-1:0] MAX_BYTES_RST = 13'd1024;
	localparam logic [BYTE_CNT_W-1:0] BYTE_CNT_MAX  = 13'd8191;

	// summary status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CRC_ERR  = 2'd1;
	localparam logic [1:0] ST_SIZE_ERR = 2'd2;

	// header byte positions
	localparam logic [BYTE_CNT_W-1:0] POS_TABLE_ID = 13'd0;
	localparam logic [BYTE_CNT_W-1:0] POS_LEN_HI   = 13'd1;
	localparam logic [BYTE_CNT_W-1:0] POS_LEN_LO   = 13'd2;
	localparam logic [BYTE_CNT_W-1:0] POS_VERSION  = 13'd5;
	localparam logic [BYTE_CNT_W-1:0] POS_SEC_NUM  = 13'd6;
	localparam logic [BYTE_CNT_W-1:0] POS_LAST_SEC = 13'd7;
	localparam logic [BYTE_CNT_W-1:0] LOOP_START   = 13'd8;

	localparam logic signed [LOOP_W-1:0] LOOP_HDR_BYTES = 14'sd9;
	localparam logic signed [LOOP_W-1:0] DESC_HDR_BYTES = 14'sd2;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        is_summary;
		logic [1:0]  status;
		logic [7:0]  tbl_id;
		logic        syntax_indicator;
		logic [11:0] section_len;
		logic [4:0]  version;
		logic        current_next;
		logic [7:0]  section_index;
		logic [7:0]  last_section_index;
		logic [7:0]  desc_tag;
		logic [7:0]  desc_len;
		logic [5:0]  item_count;
	} psdp_result_t;

	// up to two results per byte, r0 goes out first
	typedef struct packed {
		logic [1:0]   n;
		psdp_result_t r0;
		psdp_result_t r1;
	} psdp_push_t;

	// MSB-first CRC-32 over one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'd0};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== sv/psdp_parser.sv =====
// Byte-level section parser: input stage, header capture, descriptor walk, CRC.
// Produces up to two results per byte for the result queue. Uses psdp_pkg.
module psdp_parser import psdp_pkg::*; #(
	parameter int MAX_DESCRIPTORS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_data,
	input  logic                  in_last,
	input  logic [BYTE_CNT_W-1:0] min_bytes,
	input  logic [BYTE_CNT_W-1:0] max_bytes,
	input  logic                  room,
	output psdp_push_t            push
);

	localparam int CNT_W = $clog2(MAX_DESCRIPTORS + 1);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_DESCRIPTORS);

	logic                    valid_s1;
	logic [7:0]              data_s1;
	logic                    last_s1;
	logic                    adv;

	logic [BYTE_CNT_W-1:0]   byte_cnt_q;
	logic [31:0]             crc_q;
	logic [7:0]              tbl_id_q;
	logic                    syntax_q;
	logic [11:0]             sec_len_q;
	logic [4:0]              version_q;
	logic                    cur_next_q;
	logic [7:0]              sec_num_q;
	logic [7:0]              last_sec_q;
	logic signed [LOOP_W-1:0] loop_rem_q;
	logic [BYTE_CNT_W-1:0]   next_off_q;
	logic [CNT_W-1:0]        desc_cnt_q;
	logic [7:0]              pend_tag_q;

	logic [BYTE_CNT_W-1:0]   p;
	logic [31:0]             crc_n;
	logic [7:0]              tbl_id_n;
	logic                    syntax_n;
	logic [11:0]             sec_len_n;
	logic [4:0]              version_n;
	logic                    cur_next_n;
	logic [7:0]              sec_num_n;
	logic [7:0]              last_sec_n;
	logic signed [LOOP_W-1:0] loop_eff;
	logic signed [LOOP_W-1:0] loop_rem_n;
	logic                    desc_ok;
	logic                    hit_tag;
	logic                    hit_len;
	logic [CNT_W-1:0]        desc_cnt_n;
	logic [BYTE_CNT_W-1:0]   next_off_n;
	logic [BYTE_CNT_W-1:0]   byte_cnt_inc;
	logic [1:0]              status;
	psdp_result_t            rec;
	psdp_result_t            summ;

	assign in_ready = !valid_s1 || room;
	assign adv      = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
			last_s1 <= in_last;
		end
	end

	assign p = byte_cnt_q;
	assign crc_n = crc32_byte(crc_q, data_s1);

	always_comb begin
		tbl_id_n   = tbl_id_q;
		syntax_n   = syntax_q;
		sec_len_n  = sec_len_q;
		version_n  = version_q;
		cur_next_n = cur_next_q;
		sec_num_n  = sec_num_q;
		last_sec_n = last_sec_q;
		loop_eff   = loop_rem_q;
		case (p)
			POS_TABLE_ID: tbl_id_n = data_s1;
			POS_LEN_HI: begin
				syntax_n        = data_s1[7];
				sec_len_n[11:8] = data_s1[3:0];
			end
			POS_LEN_LO: begin
				sec_len_n[7:0] = data_s1;
				loop_eff = $signed({2'b00, sec_len_q[11:8], data_s1}) - LOOP_HDR_BYTES;
			end
			POS_VERSION: begin
				version_n  = data_s1[5:1];
				cur_next_n = data_s1[0];
			end
			POS_SEC_NUM:  sec_num_n  = data_s1;
			POS_LAST_SEC: last_sec_n = data_s1;
			default: ;
		endcase
	end

	// descriptor walk: tag byte at next_off, length byte right after it
	assign desc_ok = (desc_cnt_q < CNT_LIMIT) && (loop_eff >= DESC_HDR_BYTES);
	assign hit_tag = desc_ok && (p == next_off_q);
	assign hit_len = desc_ok && (p == next_off_q + 13'd1);

	assign loop_rem_n = hit_len ?
		loop_eff - $signed({6'd0, data_s1}) - DESC_HDR_BYTES : loop_eff;
	assign next_off_n = hit_len ? next_off_q + {5'd0, data_s1} + 13'd2 : next_off_q;
	assign desc_cnt_n = hit_len ? desc_cnt_q + CNT_W'(1) : desc_cnt_q;

	assign byte_cnt_inc = (byte_cnt_q == BYTE_CNT_MAX) ? byte_cnt_q : byte_cnt_q + 13'd1;

	always_comb begin
		if (byte_cnt_inc < min_bytes || byte_cnt_inc > max_bytes) begin
			status = ST_SIZE_ERR;
		end else if (crc_n != 32'd0) begin
			status = ST_CRC_ERR;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		rec.is_summary         = 1'b0;
		rec.status             = ST_OK;
		rec.tbl_id             = tbl_id_n;
		rec.syntax_indicator   = syntax_n;
		rec.section_len        = sec_len_n;
		rec.version            = version_n;
		rec.current_next       = cur_next_n;
		rec.section_index      = sec_num_n;
		rec.last_section_index = last_sec_n;
		rec.desc_tag           = pend_tag_q;
		rec.desc_len           = data_s1;
		rec.item_count         = 6'(desc_cnt_q);

		summ            = rec;
		summ.is_summary = 1'b1;
		summ.status     = status;
		summ.desc_tag   = 8'd0;
		summ.desc_len   = 8'd0;
		summ.item_count = 6'(desc_cnt_n);

		push.r0 = hit_len ? rec : summ;
		push.r1 = summ;
		if (!adv) begin
			push.n = 2'd0;
		end else begin
			push.n = {1'b0, hit_len} + {1'b0, last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			crc_q      <= CRC_INIT;
			tbl_id_q   <= '0;
			syntax_q   <= 1'b0;
			sec_len_q  <= '0;
			version_q  <= '0;
			cur_next_q <= 1'b0;
			sec_num_q  <= '0;
			last_sec_q <= '0;
			loop_rem_q <= '0;
			next_off_q <= LOOP_START;
			desc_cnt_q <= '0;
			pend_tag_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				byte_cnt_q <= '0;
				crc_q      <= CRC_INIT;
				tbl_id_q   <= '0;
				syntax_q   <= 1'b0;
				sec_len_q  <= '0;
				version_q  <= '0;
				cur_next_q <= 1'b0;
				sec_num_q  <= '0;
				last_sec_q <= '0;
				loop_rem_q <= '0;
				next_off_q <= LOOP_START;
				desc_cnt_q <= '0;
				pend_tag_q <= '0;
			end else begin
				byte_cnt_q <= byte_cnt_inc;
				crc_q      <= crc_n;
				tbl_id_q   <= tbl_id_n;
				syntax_q   <= syntax_n;
				sec_len_q  <= sec_len_n;
				version_q  <= version_n;
				cur_next_q <= cur_next_n;
				sec_num_q  <= sec_num_n;
				last_sec_q <= last_sec_n;
				loop_rem_q <= loop_rem_n;
				next_off_q <= next_off_n;
				desc_cnt_q <= desc_cnt_n;
				if (hit_tag) begin
					pend_tag_q <= data_s1;
				end
			end
		end
	end

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		desc_cnt_q <= CNT_LIMIT)
		else $error("descriptor count beyond limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (byte_cnt_q == '0 && desc_cnt_q == '0 && crc_q == CRC_INIT))
		else $error("section state not cleared after last byte");

	a_cnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !last_s1) |=> (byte_cnt_q >= $past(byte_cnt_q) && byte_cnt_q != '0))
		else $error("byte counter went backward mid-section");

endmodule

// ===== sv/psdp_out_fifo.sv =====
// Result queue: takes zero, one or two results per cycle, hands out one.
// Signals room while two more entries fit. Uses psdp_pkg.
module psdp_out_fifo import psdp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  psdp_push_t   push,
	output logic         room,
	output logic         out_valid,
	input  logic         out_ready,
	output psdp_result_t out_data
);

	psdp_result_t        mem [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic                pop;
	logic [RQ_PTR_W-1:0] wr_ptr_1;

	assign room      = cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign wr_ptr_1  = wr_ptr_q + RQ_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_ptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + RQ_CNT_W'(push.n) - RQ_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("result pushed without room");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RQ_CNT_W'(RQ_DEPTH))
		else $error("result queue count out of range");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.n == 2'd0) |=> cnt_q == $past(cnt_q) - RQ_CNT_W'(1))
		else $error("queue count wrong after pop");

endmodule

// ===== sv/psi_section_descriptor_parser_top.sv =====
// Top level of the PSI section descriptor parser.
// Instantiates psdp_parser and psdp_out_fifo; holds the size limit registers. Uses psdp_pkg.
//
// Usage:
//  - s_axis takes one section byte per item (tdata[7:0]); tlast marks the final byte.
//  - m_axis gives one record per descriptor header found in the loop, and on the
//    final byte a summary with tlast high (status: ok, crc error, size error).
//  - cfg writes the size limits: index 0 min bytes, index 1 max bytes. cfg_ready is
//    always high; write only while no section byte is in flight.
// Timing:
//  - One byte per cycle sustained while the result queue has room. A byte is held in the
//    input register, and its results enter the result queue from there, so a result is
//    visible at m_axis only after the byte has passed the input register.
//  - A byte can give two results (last descriptor record and summary); the queue
//    of four drains one per cycle while m_axis_tready is high.
//  - When m_axis stalls, the queue fills; s_axis_tready drops while a byte waits in
//    the input register and fewer than two entries are free; nothing is lost.
// Reset: arst_n clears the section state, the queue and restores the limits 12/1024.
module psi_section_descriptor_parser_top import psdp_pkg::*; #(
	parameter int MAX_DESCRIPTORS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [1:0] status, [9:2] table id, [10] syntax_indicator, [22:11] section_len,
	// [27:23] version, [28] current_next, [36:29] section_index,
	// [44:37] last_section_index, [52:45] desc_tag, [60:53] desc_len,
	// [66:61] item_count, [71:67] zero
	output logic [71:0]           m_axis_tdata,
	output logic                  m_axis_tlast,   // is_summary
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BYTE_CNT_W-1:0] cfg_data
);

	logic [BYTE_CNT_W-1:0] min_bytes_q;
	logic [BYTE_CNT_W-1:0] max_bytes_q;
	logic                  room;
	psdp_push_t            push;
	psdp_result_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bytes_q <= MIN_BYTES_RST;
			max_bytes_q <= MAX_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_BYTES: min_bytes_q <= cfg_data;
				CFG_MAX_BYTES: max_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	psdp_parser #(
		.MAX_DESCRIPTORS(MAX_DESCRIPTORS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.min_bytes(min_bytes_q),
		.max_bytes(max_bytes_q),
		.room     (room),
		.push     (push)
	);

	psdp_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (res)
	);

	assign m_axis_tlast = res.is_summary;
	assign m_axis_tdata = {5'd0, res.item_count, res.desc_len, res.desc_tag,
		res.last_section_index, res.section_index, res.current_next, res.version,
		res.section_len, res.syntax_indicator, res.tbl_id, res.status};

endmodule

// ===== test/psi_section_descriptor_parser_top_test.sv =====
// Stream-level test of psi_section_descriptor_parser_top: feeds whole sections, checks
// every descriptor record and section summary against a cycle-free section tracker.
// Depends on psdp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module psi_section_descriptor_parser_top_test;
	import psdp_pkg::*;

	localparam int DESC_LIMIT     = 32;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 240;
	localparam longint TIMEOUT_NS = 64'd20_000_000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

	typedef logic [7:0] byte_q_t[$];
	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} feed_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_CNT_W-1:0] cfg_data = '0;

	psi_section_descriptor_parser_top #(
		.MAX_DESCRIPTORS(DESC_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	feed_item_t byte_feed[$];
	psdp_result_t expected_results[$];

	// traffic shaping
	int idle_odds = 0;     // 0: no idling, else one gap in idle_odds chances
	int src_gap = 0;
	int sink_gap = 0;
	bit hold_armed = 0;
	logic sink_hold = 1'b0;

	// section tracker state
	logic [BYTE_CNT_W-1:0] min_lim = MIN_BYTES_RST;
	logic [BYTE_CNT_W-1:0] max_lim = MAX_BYTES_RST;
	logic [BYTE_CNT_W-1:0] pos_cnt = '0;
	logic [31:0] crc_acc = CRC_INIT;
	logic [7:0] h_tid = '0;
	logic h_syn = 1'b0;
	logic [11:0] h_len = '0;
	logic [4:0] h_ver = '0;
	logic h_cn = 1'b0;
	logic [7:0] h_sec = '0;
	logic [7:0] h_lsec = '0;
	int loop_left = 0;
	int next_off = int'(LOOP_START);
	int desc_cnt = 0;
	logic [7:0] pend_tag = '0;

	// tallies
	int mismatches = 0;
	int results_seen = 0;
	int bytes_sent = 0;
	int sections_done = 0;
	int records_made = 0;
	int n_ok = 0;
	int n_crc = 0;
	int n_size = 0;

	function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
		logic fb;
		for (int k = 7; k >= 0; k--) begin
			fb = c[31] ^ d[k];
			c = {c[30:0], 1'b0};
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic psdp_result_t make_record(input logic summ, input logic [1:0] st,
			input logic [7:0] tag, input logic [7:0] dl);
		psdp_result_t r;
		r.is_summary = summ;
		r.status = st;
		r.tbl_id = h_tid;
		r.syntax_indicator = h_syn;
		r.section_len = h_len;
		r.version = h_ver;
		r.current_next = h_cn;
		r.section_index = h_sec;
		r.last_section_index = h_lsec;
		r.desc_tag = tag;
		r.desc_len = dl;
		r.item_count = desc_cnt[5:0];
		return r;
	endfunction

	// advance the section tracker by one accepted byte and queue what it yields
	task automatic track_byte(input logic [7:0] b, input logic eos);
		int p;
		logic [1:0] st;
		p = int'(pos_cnt);
		crc_acc = crc_next(crc_acc, b);
		case (pos_cnt)
			POS_TABLE_ID: h_tid = b;
			POS_LEN_HI: begin
				h_syn = b[7];
				h_len[11:8] = b[3:0];
			end
			POS_LEN_LO: begin
				h_len[7:0] = b;
				loop_left = int'(h_len) - int'(LOOP_HDR_BYTES);
			end
			POS_VERSION: begin
				h_ver = b[5:1];
				h_cn = b[0];
			end
			POS_SEC_NUM: h_sec = b;
			POS_LAST_SEC: h_lsec = b;
			default: ;
		endcase
		if (desc_cnt < DESC_LIMIT && loop_left >= int'(DESC_HDR_BYTES)) begin
			if (p == next_off) begin
				pend_tag = b;
			end else if (p == next_off + 1) begin
				expected_results.push_back(make_record(1'b0, ST_OK, pend_tag, b));
				records_made++;
				desc_cnt++;
				next_off += int'(b) + int'(DESC_HDR_BYTES);
				loop_left -= int'(b) + int'(DESC_HDR_BYTES);
			end
		end
		if (pos_cnt != BYTE_CNT_MAX)
			pos_cnt++;
		if (eos) begin
			// size check wins over the crc check
			if (pos_cnt < min_lim || pos_cnt > max_lim) begin
				st = ST_SIZE_ERR;
				n_size++;
			end else if (crc_acc != 32'd0) begin
				st = ST_CRC_ERR;
				n_crc++;
			end else begin
				st = ST_OK;
				n_ok++;
			end
			expected_results.push_back(make_record(1'b1, st, 8'd0, 8'd0));
			sections_done++;
			pos_cnt = '0;
			crc_acc = CRC_INIT;
			h_tid = '0;
			h_syn = 1'b0;
			h_len = '0;
			h_ver = '0;
			h_cn = 1'b0;
			h_sec = '0;
			h_lsec = '0;
			loop_left = 0;
			next_off = int'(LOOP_START);
			desc_cnt = 0;
			pend_tag = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
				results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic compare_result(input psdp_result_t got, input psdp_result_t want);
		if (got.is_summary !== want.is_summary)
			report_mismatch("is_summary", 32'(got.is_summary), 32'(want.is_summary));
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.tbl_id !== want.tbl_id)
			report_mismatch("tbl_id", 32'(got.tbl_id), 32'(want.tbl_id));
		if (got.syntax_indicator !== want.syntax_indicator)
			report_mismatch("syntax_indicator", 32'(got.syntax_indicator),
				32'(want.syntax_indicator));
		if (got.section_len !== want.section_len)
			report_mismatch("section_len", 32'(got.section_len), 32'(want.section_len));
		if (got.version !== want.version)
			report_mismatch("version", 32'(got.version), 32'(want.version));
		if (got.current_next !== want.current_next)
			report_mismatch("current_next", 32'(got.current_next), 32'(want.current_next));
		if (got.section_index !== want.section_index)
			report_mismatch("section_index", 32'(got.section_index),
				32'(want.section_index));
		if (got.last_section_index !== want.last_section_index)
			report_mismatch("last_section_index", 32'(got.last_section_index),
				32'(want.last_section_index));
		if (got.desc_tag !== want.desc_tag)
			report_mismatch("desc_tag", 32'(got.desc_tag), 32'(want.desc_tag));
		if (got.desc_len !== want.desc_len)
			report_mismatch("desc_len", 32'(got.desc_len), 32'(want.desc_len));
		if (got.item_count !== want.item_count)
			report_mismatch("item_count", 32'(got.item_count), 32'(want.item_count));
	endtask

	// byte source
	always @(posedge clk or negedge arst_n) begin : feed
		feed_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_byte(s_axis_tdata, s_axis_tlast);
				bytes_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (byte_feed.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
					src_gap = $urandom_range(0, 11);
					s_axis_tvalid <= 1'b0;
				end else begin
					it = byte_feed.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= it.data;
					s_axis_tlast <= it.eos;
				end
			end
		end
	end

	// result sink and checker
	always @(posedge clk) begin : sink
		psdp_result_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.is_summary = m_axis_tlast;
			got.status = m_axis_tdata[1:0];
			got.tbl_id = m_axis_tdata[9:2];
			got.syntax_indicator = m_axis_tdata[10];
			got.section_len = m_axis_tdata[22:11];
			got.version = m_axis_tdata[27:23];
			got.current_next = m_axis_tdata[28];
			got.section_index = m_axis_tdata[36:29];
			got.last_section_index = m_axis_tdata[44:37];
			got.desc_tag = m_axis_tdata[52:45];
			got.desc_len = m_axis_tdata[60:53];
			got.item_count = m_axis_tdata[66:61];
			results_seen++;
			if (m_axis_tdata[71:67] !== 5'd0)
				report_mismatch("tdata padding", 32'(m_axis_tdata[71:67]), 32'd0);
			if (expected_results.size() == 0)
				report_mismatch("result with nothing expected", 32'(got.item_count), 32'd0);
			else
				compare_result(got, expected_results.pop_front());
		end
		if (!arst_n || sink_hold) begin
			m_axis_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
				sink_gap = $urandom_range(1, 12);
		end
	end

	// long receiver hold-off so the result queue fills and tready drops
	initial begin
		wait (hold_armed);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results still expected", expected_results.size());
		$display("Regression FAIL");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_CNT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MIN_BYTES)
			min_lim = val;
		else if (idx == CFG_MAX_BYTES)
			max_lim = val;
	endtask

	// wait until every byte is in and every result out, then let the pipe drain
	task automatic settle();
		@(negedge clk);
		while (byte_feed.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic append_crc(ref byte_q_t s);
		logic [31:0] c;
		c = CRC_INIT;
		foreach (s[i])
			c = crc_next(c, s[i]);
		s.push_back(c[31:24]);
		s.push_back(c[23:16]);
		s.push_back(c[15:8]);
		s.push_back(c[7:0]);
	endtask

	// header with consistent section length, ndesc descriptors, valid crc
	task automatic build_section(ref byte_q_t s, input int ndesc, input int len_cap);
		int dlen;
		logic [11:0] slen;
		logic [7:0] top;
		s = {};
		repeat (8) s.push_back(8'($urandom_range(0, 255)));
		repeat (ndesc) begin
			dlen = $urandom_range(0, len_cap);
			s.push_back(8'($urandom_range(0, 255)));
			s.push_back(dlen[7:0]);
			repeat (dlen) s.push_back(8'($urandom_range(0, 255)));
		end
		slen = 12'(s.size() + 4 - 3);
		top = 8'($urandom_range(0, 255));
		s[1] = {top[7:4], slen[11:8]};
		s[2] = slen[7:0];
		append_crc(s);
	endtask

	task automatic push_section(ref byte_q_t s);
		foreach (s[i])
			byte_feed.push_back('{data: s[i], eos: (i == s.size() - 1)});
	endtask

	// mostly well-formed sections, plus corrupt, mislabeled, cut short and noise
	task automatic queue_random(input int target);
		byte_q_t s;
		int kind;
		int cut;
		int pos;
		int total;
		logic [7:0] tmp;
		total = 0;
		while (total < target) begin
			kind = $urandom_range(0, 99);
			build_section(s, $urandom_range(0, 5), ($urandom_range(0, 24) == 0) ? 255 : 12);
			if (kind >= 93) begin
				s = {};
				repeat ($urandom_range(1, 40)) s.push_back(8'($urandom_range(0, 255)));
			end else if (kind >= 85) begin
				cut = $urandom_range(1, s.size());
				s = s[0:cut-1];
			end else if (kind >= 75) begin
				// wrong section length with a good crc: loop runs short or long
				s = s[0:s.size()-5];
				s[2] = s[2] + 8'($urandom_range(1, 255));
				if ($urandom_range(0, 3) == 0) begin
					tmp = s[1];
					tmp[3:0] = 4'($urandom_range(0, 15));
					s[1] = tmp;
				end
				append_crc(s);
			end else if (kind >= 65) begin
				pos = $urandom_range(0, s.size() - 1);
				s[pos] = s[pos] ^ 8'($urandom_range(1, 255));
			end
			push_section(s);
			total += s.size();
		end
	endtask

	initial begin : stimulus
		byte_q_t s;
		logic [BYTE_CNT_W-1:0] lo;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset limits: lone table id byte, minimal section with version and
		// section numbers at their top values, the same section with a bad crc byte
		s = {8'hFF};
		push_section(s);
		s = {8'h00, 8'hB0, 8'h09, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		append_crc(s);
		push_section(s);
		s[11] = s[11] ^ 8'h80;
		push_section(s);
		settle();

		idle_odds = 10;
		write_reg(CFG_MIN_BYTES, 13'd1);
		write_reg(CFG_MAX_BYTES, 13'd4099);
		@(negedge clk);
		queue_random(250);
		settle();

		// descriptor limit overflow while the receiver stalls
		write_reg(CFG_UNUSED, 13'($urandom_range(0, 8191)));
		write_reg(CFG_MIN_BYTES, MIN_BYTES_RST);
		write_reg(CFG_MAX_BYTES, MAX_BYTES_RST);
		@(negedge clk);
		build_section(s, DESC_LIMIT + 4, 3);
		push_section(s);
		queue_random(200);
		hold_armed = 1;
		settle();

		// inverted limits: every section is a size error
		write_reg(CFG_MIN_BYTES, 13'd4099);
		write_reg(CFG_MAX_BYTES, 13'd1);
		@(negedge clk);
		queue_random(100);
		settle();

		idle_odds = 3;
		lo = 13'($urandom_range(1, 40));
		write_reg(CFG_MIN_BYTES, lo);
		write_reg(CFG_MAX_BYTES, 13'($urandom_range(20, 300)));
		@(negedge clk);
		queue_random(150);
		settle();

		// closing stretch at full rate
		idle_odds = 0;
		write_reg(CFG_MIN_BYTES, MIN_BYTES_RST);
		write_reg(CFG_MAX_BYTES, MAX_BYTES_RST);
		@(negedge clk);
		queue_random(150);
		settle();

		$display("Ran %0d sections over %0d bytes: %0d ok, %0d crc error, %0d size error",
			sections_done, bytes_sent, n_ok, n_crc, n_size);
		$display("Checked %0d results including %0d descriptor records; %0d mismatches",
			results_seen, records_made, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
